// ===== rtl/core/record_sorter_with_top_score_top_macros.svh =====
// Assertion helpers used by the sorter top module.
`ifndef RECORD_SORTER_WITH_TOP_SCORE_TOP_MACROS_SVH
`define RECORD_SORTER_WITH_TOP_SCORE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rss_pkg.sv =====
package rss_pkg;

  localparam int NAME_BYTES = 32;
  localparam int NAME_W     = 256;
  localparam int NAME_LANES = NAME_W / 8;
  localparam int ID_W       = 32;
  localparam int SCORE_W    = 14;
  localparam int KEY_W      = NAME_W + ID_W;

  // Sort key: name with everything after its first zero byte cleared, then
  // the id with its sign bit flipped, so a plain unsigned compare orders it.
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [NAME_W-1:0]        name;
    logic signed [ID_W-1:0]   id;
    logic [SCORE_W-1:0]       score;
  } record_t;

  typedef struct packed {
    logic    valid;
    key_t    key;
    record_t rec;
  } cell_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic    valid;
    logic    last;
    logic    store;
    key_t    key;
    record_t rec;
  } stage_t;

endpackage

// ===== rtl/core/rss_in_if.sv =====
interface rss_in_if;
  logic               valid;
  logic               ready;
  logic [63:0]        name_word0;
  logic [63:0]        name_word1;
  logic [63:0]        name_word2;
  logic [63:0]        name_word3;
  logic signed [31:0] student_id;
  logic [13:0]        score;
  logic               last_record;

  modport source (output valid, name_word0, name_word1, name_word2, name_word3,
                  student_id, score, last_record, input ready);
  modport sink (input valid, name_word0, name_word1, name_word2, name_word3,
                student_id, score, last_record, output ready);
endinterface

// ===== rtl/core/rss_out_if.sv =====
interface rss_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        out_name_word0;
  logic [63:0]        out_name_word1;
  logic [63:0]        out_name_word2;
  logic [63:0]        out_name_word3;
  logic signed [31:0] out_id;
  logic [13:0]        out_score;
  logic               is_top_score;
  logic               last_out;

  modport source (output valid, out_name_word0, out_name_word1, out_name_word2,
                  out_name_word3, out_id, out_score, is_top_score, last_out,
                  input ready);
  modport sink (input valid, out_name_word0, out_name_word1, out_name_word2,
                out_name_word3, out_id, out_score, is_top_score, last_out,
                output ready);
endinterface

// ===== rtl/core/record_sorter_with_top_score_top.sv =====
// Record sorter: records stream in on load, one per cycle, and are placed
// straight into a chain of MAX_RECORDS sorting cells that keeps them ordered
// by name (strcmp order) and then by ascending id, equal keys in load order.
// Each record passes through the intake stage, where its sort key is
// formed, and is inserted into the chain in the next cycle. Once the record
// flagged last_record has been inserted, load is held off and the chain
// shifts toward its head, one sorted record per emit transfer; load
// reopens in the cycle after the final transfer. The record flagged
// is_top_score is the last loaded one whose score strictly beat the
// running maximum (starting at zero), that is, the first one to hold the
// highest score; none is flagged when no score is above zero. Records
// beyond MAX_RECORDS in one set are dropped, though a dropped last_record
// still starts the output.
`include "record_sorter_with_top_score_top_macros.svh"

module record_sorter_with_top_score_top #(
  parameter int MAX_RECORDS = 64
) (
  input  logic     clk,
  input  logic     rst,
  rss_in_if.sink   load,
  rss_out_if.source emit
);

  localparam int SEQ_W = $clog2(MAX_RECORDS);

  rss_pkg::stage_t     stage;
  logic [SEQ_W-1:0]    stage_seq;
  logic                best_valid;
  logic [SEQ_W-1:0]    best_index;
  logic                drain;
  logic                emit_xfer;
  logic                set_done;
  rss_pkg::cell_ctrl_t ctrl;

  rss_pkg::cell_t      cells  [MAX_RECORDS];
  logic [SEQ_W-1:0]    seqs   [MAX_RECORDS];
  logic                ahead  [MAX_RECORDS];

  rss_intake #(.MAX_RECORDS(MAX_RECORDS)) u_intake (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .busy       (drain),
    .clear      (set_done),
    .stage      (stage),
    .stage_seq  (stage_seq),
    .best_valid (best_valid),
    .best_index (best_index)
  );

  assign emit_xfer   = emit.valid && emit.ready;
  assign set_done    = drain && ((emit_xfer && emit.last_out) || !cells[0].valid);
  assign ctrl.insert = stage.valid && stage.store;
  assign ctrl.shift  = emit_xfer;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rss_pkg::cell_t   prev_c;
    logic [SEQ_W-1:0] prev_s;
    logic             prev_b;
    rss_pkg::cell_t   next_c;
    logic [SEQ_W-1:0] next_s;

    if (i == 0) begin : g_head
      assign prev_c = '0;
      assign prev_s = '0;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_c = cells[i-1];
      assign prev_s = seqs[i-1];
      assign prev_b = ahead[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_c = '0;
      assign next_s = '0;
    end else begin : g_link
      assign next_c = cells[i+1];
      assign next_s = seqs[i+1];
    end

    rss_cell #(.SEQ_W(SEQ_W)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_key     (stage.key),
      .new_rec     (stage.rec),
      .new_seq     (stage_seq),
      .prev        (prev_c),
      .prev_seq    (prev_s),
      .prev_ahead  (prev_b),
      .next        (next_c),
      .next_seq    (next_s),
      .cur         (cells[i]),
      .seq         (seqs[i]),
      .ahead       (ahead[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain <= 1'b0;
    end else begin
      priority if (stage.valid && stage.last) begin
        drain <= 1'b1;
      end else if (set_done) begin
        drain <= 1'b0;
      end else begin
        drain <= drain;
      end
    end
  end

  // The head cell doubles as the output register.
  assign emit.valid          = drain && cells[0].valid;
  assign emit.out_name_word0 = cells[0].rec.name[255:192];
  assign emit.out_name_word1 = cells[0].rec.name[191:128];
  assign emit.out_name_word2 = cells[0].rec.name[127:64];
  assign emit.out_name_word3 = cells[0].rec.name[63:0];
  assign emit.out_id         = cells[0].rec.id;
  assign emit.out_score      = cells[0].rec.score;
  assign emit.is_top_score   = best_valid && (seqs[0] == best_index);
  assign emit.last_out       = !cells[1].valid;

  `RSS_ASSERT_NOW(a_no_load_in_drain, drain, !load.ready, "load open while draining")
  `RSS_ASSERT_NOW(a_emit_only_in_drain, emit.valid, drain, "emit valid outside drain")
  `RSS_ASSERT_NEXT(a_last_starts_drain, stage.valid && stage.last, drain, "drain not started")
  `RSS_ASSERT_NEXT(a_final_ends_drain, emit_xfer && emit.last_out, !drain, "drain not ended")
  `RSS_ASSERT_NOW(a_chain_packed, cells[1].valid, cells[0].valid, "hole at chain head")

endmodule

// ===== rtl/core/rss_intake.sv =====
module rss_intake #(
  parameter int MAX_RECORDS = 64,
  localparam int SEQ_W = $clog2(MAX_RECORDS),
  localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  rss_in_if.sink              load,
  input  logic                busy,
  input  logic                clear,
  output rss_pkg::stage_t     stage,
  output logic [SEQ_W-1:0]    stage_seq,
  output logic                best_valid,
  output logic [SEQ_W-1:0]    best_index
);

  function automatic logic [rss_pkg::NAME_W-1:0] name_mask();
    logic [rss_pkg::NAME_W-1:0] m;
    m = '0;
    for (int k = 0; k < rss_pkg::NAME_LANES; k++) begin
      m[rss_pkg::NAME_W-1-8*k -: 8] = (k < rss_pkg::NAME_BYTES) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  localparam logic [rss_pkg::NAME_W-1:0] NameMask = name_mask();

  // Each byte is cleared when any earlier byte is zero; every byte is
  // resolved on its own, so this is a flat set of OR reductions.
  function automatic rss_pkg::key_t make_key(input logic [rss_pkg::NAME_W-1:0] nm,
                                             input logic [rss_pkg::ID_W-1:0] id);
    logic [rss_pkg::NAME_LANES-1:0] zero;
    logic [rss_pkg::NAME_LANES-1:0] below;
    logic [rss_pkg::NAME_W-1:0]     canon;
    for (int k = 0; k < rss_pkg::NAME_LANES; k++) begin
      zero[k] = (nm[rss_pkg::NAME_W-1-8*k -: 8] == 8'h00);
    end
    for (int k = 0; k < rss_pkg::NAME_LANES; k++) begin
      below = rss_pkg::NAME_LANES'((64'd1 << k) - 64'd1);
      canon[rss_pkg::NAME_W-1-8*k -: 8] =
        (|(zero & below)) ? 8'h00 : nm[rss_pkg::NAME_W-1-8*k -: 8];
    end
    return {canon, ~id[rss_pkg::ID_W-1], id[rss_pkg::ID_W-2:0]};
  endfunction

  logic [CNT_W-1:0]            count;
  logic [rss_pkg::SCORE_W-1:0] best_score;
  logic                        accept;
  logic                        room;
  logic [rss_pkg::NAME_W-1:0]  name_in;

  assign load.ready = !busy && !(stage.valid && stage.last);
  assign accept     = load.valid && load.ready;
  assign room       = (count < CNT_W'(MAX_RECORDS));
  assign name_in    = {load.name_word0, load.name_word1, load.name_word2, load.name_word3}
                      & NameMask;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
      count       <= '0;
      best_score  <= '0;
      best_index  <= '0;
      best_valid  <= 1'b0;
    end else begin
      stage.valid <= accept;
      if (clear) begin
        count      <= '0;
        best_score <= '0;
        best_index <= '0;
        best_valid <= 1'b0;
      end else if (accept && room) begin
        count <= count + CNT_W'(1);
        if (load.score > best_score) begin
          best_score <= load.score;
          best_index <= count[SEQ_W-1:0];
          best_valid <= 1'b1;
        end
      end
    end
    if (accept) begin
      stage.last      <= load.last_record;
      stage.store     <= room;
      stage.key       <= make_key(name_in, load.student_id);
      stage.rec.name  <= name_in;
      stage.rec.id    <= load.student_id;
      stage.rec.score <= load.score;
      stage_seq       <= count[SEQ_W-1:0];
    end
  end

endmodule

// ===== rtl/core/rss_cell.sv =====
module rss_cell #(
  parameter int SEQ_W = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rss_pkg::cell_ctrl_t  ctrl,
  input  rss_pkg::key_t        new_key,
  input  rss_pkg::record_t     new_rec,
  input  logic [SEQ_W-1:0]     new_seq,
  input  rss_pkg::cell_t       prev,
  input  logic [SEQ_W-1:0]     prev_seq,
  input  logic                 prev_ahead,
  input  rss_pkg::cell_t       next,
  input  logic [SEQ_W-1:0]     next_seq,
  output rss_pkg::cell_t       cur,
  output logic [SEQ_W-1:0]     seq,
  output logic                 ahead
);

  logic             valid;
  rss_pkg::key_t    key;
  rss_pkg::record_t rec;
  rss_pkg::cell_t   cur_next;
  logic [SEQ_W-1:0] seq_next;

  assign cur = '{valid: valid, key: key, rec: rec};

  // The new record lands ahead of every stored record with a strictly larger
  // key, so equal keys stay in load order.
  assign ahead = !valid || (key > new_key);

  always_comb begin
    cur_next = cur;
    seq_next = seq;
    priority if (ctrl.shift) begin
      cur_next = next;
      seq_next = next_seq;
    end else if (ctrl.insert && ahead) begin
      if (prev_ahead) begin
        cur_next = prev;
        seq_next = prev_seq;
      end else begin
        cur_next = '{valid: 1'b1, key: new_key, rec: new_rec};
        seq_next = new_seq;
      end
    end else begin
      cur_next = cur;
      seq_next = seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cur_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    key <= cur_next.key;
    rec <= cur_next.rec;
    seq <= seq_next;
  end

endmodule
